### hw/rtl/gift64_pkg.sv
// ----------------------------------------------------------------------------
// GIFT-64 package
// Shared constants and round functions of the GIFT-64-128 encryption pipeline.
// ----------------------------------------------------------------------------
package gift64_pkg;

  // Number of cipher rounds, one pipeline stage each.
  localparam int unsigned ROUNDS = 28;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } cfg_reg_e;

  // The 4-bit GIFT S-box.
  localparam logic [3:0] SBOX [16] = '{
    4'h1, 4'hA, 4'h4, 4'hC, 4'h6, 4'hF, 4'h3, 4'h9,
    4'h2, 4'hD, 4'hB, 4'h7, 4'h5, 4'h0, 4'h8, 4'hE
  };

  // Applies the S-box to all sixteen nibbles.
  function automatic logic [63:0] sub_cells(logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = SBOX[x[4*n +: 4]];
    end
    return r;
  endfunction

  // The fixed GIFT-64 bit permutation; pure wiring.
  function automatic logic [63:0] perm_bits(logic [63:0] x);
    logic [63:0] r;
    int          q;
    int          m;
    int          lo;
    int          dst;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      q   = i >> 4;
      m   = i & 15;
      lo  = i & 3;
      dst = 4 * q + 16 * ((3 * (m >> 2) + lo) & 3) + lo;
      r[dst] = x[i];
    end
    return r;
  endfunction

  // Round constant of round r, counted from zero, from the 6-bit LFSR.
  function automatic logic [5:0] round_const(int unsigned r);
    logic [5:0] c;
    c = '0;
    for (int unsigned j = 0; j <= r; j++) begin
      c = {c[4:0], ~(c[5] ^ c[4])};
    end
    return c;
  endfunction

  // Builds the 64-bit round key from key words k0 and k1 and the round constant.
  function automatic logic [63:0] round_key(logic [31:0] k, logic [5:0] c);
    logic [63:0] rk;
    rk = '0;
    for (int i = 0; i < 16; i++) begin
      rk[4*i]     = k[i];
      rk[4*i + 1] = k[16 + i];
    end
    rk[23] = c[5];
    rk[19] = c[4];
    rk[15] = c[3];
    rk[11] = c[2];
    rk[7]  = c[1];
    rk[3]  = c[0];
    rk[63] = 1'b1;
    return rk;
  endfunction

  // Key state update between rounds: word rotation and two 16-bit rotations.
  function automatic logic [127:0] key_update(logic [127:0] ks);
    logic [15:0] k0;
    logic [15:0] k1;
    k0 = ks[15:0];
    k1 = ks[31:16];
    return {k1[1:0], k1[15:2], k0[11:0], k0[15:12], ks[127:32]};
  endfunction

endpackage

### hw/rtl/gift64_block_encrypt_unit.sv
// ----------------------------------------------------------------------------
// GIFT-64-128 block encryption unit
// Fully unrolled GIFT-64 encryption with one register stage per round.
// ----------------------------------------------------------------------------
// The unit takes one 64-bit plaintext item per cycle while the pipeline is not
// held and returns its ciphertext through the 28 round stages, each of which
// holds one item in flight. The 128-bit key is held in two configuration
// registers and must be written while no item is in flight. All stages
// advance together: when the output item is held by the downstream stall,
// the whole pipeline holds and the input is stalled.

module gift64_block_encrypt_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] plaintext_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] ciphertext_o
);

  localparam int unsigned Last = gift64_pkg::ROUNDS - 1;

  logic [63:0]  key_low_q;
  logic [63:0]  key_high_q;
  logic [127:0] key_state [gift64_pkg::ROUNDS];
  logic [63:0]  state_d   [gift64_pkg::ROUNDS];
  logic [63:0]  state_q   [gift64_pkg::ROUNDS];
  logic [gift64_pkg::ROUNDS-1:0] valid_q;
  logic         advance;

  // Key registers, written through the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (gift64_pkg::cfg_reg_e'(cfg_index_i))
        gift64_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        gift64_pkg::CFG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished item is waiting at the output.
  assign advance    = !(valid_q[Last] && out_stall_i);
  assign in_stall_o = !advance;

  // Key schedule: the key state of each round is a fixed rewiring of the key.
  assign key_state[0] = {key_high_q, key_low_q};
  for (genvar r = 1; r < gift64_pkg::ROUNDS; r++) begin : g_key
    assign key_state[r] = gift64_pkg::key_update(key_state[r-1]);
  end

  // One round per stage: S-box layer, bit permutation, round key addition.
  for (genvar r = 0; r < gift64_pkg::ROUNDS; r++) begin : g_round
    logic [63:0] round_in;
    if (r == 0) begin : g_first
      assign round_in = plaintext_i;
    end else begin : g_next
      assign round_in = state_q[r-1];
    end
    assign state_d[r] = gift64_pkg::perm_bits(gift64_pkg::sub_cells(round_in))
                        ^ gift64_pkg::round_key(key_state[r][31:0],
                                                gift64_pkg::round_const(r));

    always_ff @(posedge clk_i) begin
      if (advance) begin
        state_q[r] <= state_d[r];
      end
    end
  end

  // Valid bits travel with the items through the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[gift64_pkg::ROUNDS-1:0] << 1} | {{Last{1'b0}}, in_valid_i};
    end
  end

  assign out_valid_o  = valid_q[Last];
  assign ciphertext_o = state_q[Last];

  // An input stall only ever comes from a held output item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output item");

  // An accepted item occupies the first stage in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted item missing from the first stage");

  // While the pipeline holds, no stage gains or loses an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(valid_q))
    else $error("pipeline occupancy changed during a hold");

  // While the pipeline holds, the first stage keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(state_q[0]))
    else $error("first stage data changed during a hold");

endmodule
